@@ sv/circle_point_generator_assert.svh @@
// assertion macros used by the circle point generator checker
`ifndef CIRCLE_POINT_GENERATOR_ASSERT_SVH
`define CIRCLE_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cpg_pkg.sv @@
// shared constants and types for the circle point generator
package cpg_pkg;

    // request codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // width of the plotted point fields
    localparam int OUT_BITS = 13;

    // decision term constants of the midpoint recurrence
    localparam int DEC_INIT = 3;
    localparam int DEC_DIAG = 10;
    localparam int DEC_AXIS = 6;

    // points per octet and queue depth between front and back
    localparam int OCTET_SIZE  = 8;
    localparam int QUEUE_DEPTH = 2;

    // queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ sv/circle_point_generator.sv @@
// Midpoint circle rasterizer: a front part steps the recurrence, a back part emits points.
// A request is written into the queue, then loaded by the back into its output registers.
// A start or active step request yields eight points, an idle step one idle reply. The back
// emits a point per cycle while out_stall is low; the front steps once per cycle unless in_stall.
// A two-entry queue holds the octet being emitted plus one more request from the front.
// Reset (rst_n low, asynchronous) clears the circle state, empties the queue, drops out_valid.
module circle_point_generator #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic [COORD_BITS-1:0]  center_x,
    input  logic [COORD_BITS-1:0]  center_y,
    input  logic [RADIUS_BITS-1:0] radius,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [cpg_pkg::OUT_BITS-1:0] point_x,
    output logic signed [cpg_pkg::OUT_BITS-1:0] point_y,
    output logic                   last_of_run,
    output logic                   circle_complete,
    output logic                   idle_reply
);

    localparam int ENTRY_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 2;

    logic                  push, pop;
    logic [ENTRY_BITS-1:0] push_data, head_data;
    cpg_pkg::q_status_t    q_status;

    // request intake and recurrence
    cpg_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // octet queue
    cpg_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    // point emission
    cpg_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_data       (head_data),
        .q_status        (q_status),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .point_x         (point_x),
        .point_y         (point_y),
        .last_of_run     (last_of_run),
        .circle_complete (circle_complete),
        .idle_reply      (idle_reply)
    );

endmodule

@@ sv/cpg_queue.sv @@
// small register queue between the front and back parts
module cpg_queue #(
    parameter int WIDTH = 46
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output cpg_pkg::q_status_t status
);

    localparam int DEPTH    = cpg_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;
    logic [PTR_BITS:0]   count_next;

    // status and head
    assign status.full  = (count_reg == (PTR_BITS + 1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/cpg_front.sv @@
// front part: accepts requests, runs the midpoint recurrence, queues octets
module cpg_front #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic [COORD_BITS-1:0]  center_x,
    input  logic [COORD_BITS-1:0]  center_y,
    input  logic [RADIUS_BITS-1:0] radius,
    input  cpg_pkg::q_status_t     q_status,
    output logic                   push,
    output logic [2*COORD_BITS+2*RADIUS_BITS+1:0] push_data
);

    localparam int OFS_BITS = RADIUS_BITS + 2;
    localparam int DEC_BITS = RADIUS_BITS + 6;

    logic [COORD_BITS-1:0]      cx_reg, cx_next;
    logic [COORD_BITS-1:0]      cy_reg, cy_next;
    logic signed [OFS_BITS-1:0] x_reg, x_next;
    logic signed [OFS_BITS-1:0] y_reg, y_next;
    logic signed [DEC_BITS-1:0] d_reg, d_next;
    logic                       active_reg, active_next;

    logic                       accept;
    logic                       start;
    logic                       emit;
    logic [COORD_BITS-1:0]      cx_cur, cy_cur;
    logic signed [OFS_BITS-1:0] x_cur, y_cur, x_adv, y_adv;
    logic signed [DEC_BITS-1:0] d_cur, d_adv;
    logic                       still_on;

    assign accept   = in_valid && !q_status.full;
    assign in_stall = q_status.full;
    assign push     = accept;
    assign start    = (mode == cpg_pkg::MODE_START);
    assign emit     = start || active_reg;

    // current offset pair: a start loads it from the request
    always_comb
    begin
        if (start)
        begin
            cx_cur = center_x;
            cy_cur = center_y;
            x_cur  = '0;
            y_cur  = signed'(OFS_BITS'(radius));
            d_cur  = DEC_BITS'(cpg_pkg::DEC_INIT) - signed'(DEC_BITS'(radius) << 1);
        end
        else
        begin
            cx_cur = cx_reg;
            cy_cur = cy_reg;
            x_cur  = x_reg;
            y_cur  = y_reg;
            d_cur  = d_reg;
        end
    end

    // advance to the next offset pair
    always_comb
    begin
        x_adv = x_cur + OFS_BITS'(1);
        if (d_cur > 0)
        begin
            y_adv = y_cur - OFS_BITS'(1);
            d_adv = d_cur + (DEC_BITS'(x_adv - y_adv) <<< 2)
                  + DEC_BITS'(cpg_pkg::DEC_DIAG);
        end
        else
        begin
            y_adv = y_cur;
            d_adv = d_cur + (DEC_BITS'(x_adv) <<< 2) + DEC_BITS'(cpg_pkg::DEC_AXIS);
        end
        still_on = (x_adv <= y_adv);
    end

    // queue entry: center, offsets, final flag, idle flag
    assign push_data = {cx_cur, cy_cur, x_cur[RADIUS_BITS-1:0], y_cur[RADIUS_BITS-1:0],
                        !still_on, !emit};

    // next state
    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        active_next = active_reg;
        if (accept && emit)
        begin
            cx_next     = cx_cur;
            cy_next     = cy_cur;
            x_next      = x_adv;
            y_next      = y_adv;
            d_next      = d_adv;
            active_next = still_on;
        end
    end

    // circle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            d_reg      <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            d_reg      <= d_next;
            active_reg <= active_next;
        end
    end

endmodule

@@ sv/cpg_back.sv @@
// back part: walks each queued octet, driving one point per cycle while not stalled
module cpg_back #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [2*COORD_BITS+2*RADIUS_BITS+1:0] head_data,
    input  cpg_pkg::q_status_t     q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [cpg_pkg::OUT_BITS-1:0] point_x,
    output logic signed [cpg_pkg::OUT_BITS-1:0] point_y,
    output logic                   last_of_run,
    output logic                   circle_complete,
    output logic                   idle_reply
);

    localparam int OB        = cpg_pkg::OUT_BITS;
    localparam int WIDE_BITS = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
    localparam int CALC_BITS = (WIDE_BITS > OB) ? WIDE_BITS : OB;
    localparam int K_BITS    = $clog2(cpg_pkg::OCTET_SIZE);
    localparam logic [K_BITS-1:0] K_LAST = K_BITS'(cpg_pkg::OCTET_SIZE - 1);

    logic [COORD_BITS-1:0]       h_cx, h_cy;
    logic [RADIUS_BITS-1:0]      h_x, h_y;
    logic                        h_fin, h_idle;
    logic signed [CALC_BITS-1:0] cx_s, cy_s, a_s, b_s, px_s, py_s;
    logic                        out_free, load, at_last;

    logic [K_BITS-1:0]   k_reg, k_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [OB-1:0] px_reg, py_reg;
    logic                last_reg, done_reg, idle_reg;

    assign {h_cx, h_cy, h_x, h_y, h_fin, h_idle} = head_data;

    assign out_free = !out_valid_reg || !out_stall;
    assign load     = out_free && !q_status.empty;
    assign at_last  = h_idle || (k_reg == K_LAST);
    assign pop      = load && at_last;

    // octant selection: bit 2 swaps the offsets, bits 0 and 1 pick the signs
    always_comb
    begin
        cx_s = signed'(CALC_BITS'(h_cx));
        cy_s = signed'(CALC_BITS'(h_cy));
        a_s  = signed'(CALC_BITS'(k_reg[2] ? h_y : h_x));
        b_s  = signed'(CALC_BITS'(k_reg[2] ? h_x : h_y));
        px_s = k_reg[0] ? (cx_s - a_s) : (cx_s + a_s);
        py_s = k_reg[1] ? (cy_s - b_s) : (cy_s + b_s);
    end

    // point index and output valid
    always_comb
    begin
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            k_next         = at_last ? '0 : k_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= h_idle ? '0 : px_s[OB-1:0];
            py_reg   <= h_idle ? '0 : py_s[OB-1:0];
            last_reg <= at_last;
            done_reg <= h_idle || ((k_reg == K_LAST) && h_fin);
            idle_reg <= h_idle;
        end
    end

    assign out_valid       = out_valid_reg;
    assign point_x         = px_reg;
    assign point_y         = py_reg;
    assign last_of_run     = last_reg;
    assign circle_complete = done_reg;
    assign idle_reply      = idle_reg;

endmodule

@@ sv/cpg_checker.sv @@
// port-level checker for the circle point generator and its bind
`include "circle_point_generator_assert.svh"

module cpg_checker #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   mode,
    input logic [COORD_BITS-1:0]  center_x,
    input logic [COORD_BITS-1:0]  center_y,
    input logic [RADIUS_BITS-1:0] radius,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic signed [cpg_pkg::OUT_BITS-1:0] point_x,
    input logic signed [cpg_pkg::OUT_BITS-1:0] point_y,
    input logic                   last_of_run,
    input logic                   circle_complete,
    input logic                   idle_reply
);

    logic out_take;

    assign out_take = out_valid && !out_stall;

    // a stalled result holds
    `CPG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(point_x) && $stable(point_y) && $stable(last_of_run) && $stable(circle_complete) && $stable(idle_reply), "stalled result changed")

    // an idle reply carries no point and closes its run and the circle
    `CPG_ASSERT_NOW(a_idle_form, out_valid && idle_reply, last_of_run && circle_complete && point_x == '0 && point_y == '0, "malformed idle reply")

    // circle completion only on the last point of an octet
    `CPG_ASSERT_NOW(a_done_last, out_valid && circle_complete, last_of_run, "completion not on last result")

    // inside an octet the next result is a point, never an idle reply
    `CPG_ASSERT_NEXT(a_octet_cont, out_take && !last_of_run, !(out_valid && idle_reply), "idle reply inside an octet")

endmodule

bind circle_point_generator cpg_checker #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
) u_cpg_checker (.*);
